FILE: rtl/imuctf_pkg.sv
// ----------------------------------------------------------------------------
// imuctf_pkg
// Shared types, constants and helpers for the IMU complementary tilt filter.
// ----------------------------------------------------------------------------
package imuctf_pkg;

    localparam int RAW_W      = 16;
    localparam int TIME_W     = 32;
    localparam int ANG_W      = 32;
    localparam int BIAS_W     = 20;
    localparam int SENS_W     = 8;
    localparam int WGT_W      = 17;
    localparam int MAG_W      = 20;
    localparam int DIV_W      = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int IN_W       = 128;
    localparam int OUT_W      = 192;
    localparam int ATAN_LEN   = 24;

    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic [SENS_W-1:0] SENS_RESET   = 8'd131;
    localparam logic [WGT_W-1:0]  WEIGHT_RESET = 17'd62915;
    localparam logic [WGT_W-1:0]  WEIGHT_ONE   = 17'd65536;
    localparam int                SENS_SCALE   = 1000;
    localparam logic signed [31:0] DEG90_Q16   = 32'sd5898240;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SENS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 3'd4;

    typedef struct packed {
        logic signed [RAW_W-1:0]  ax;
        logic signed [RAW_W-1:0]  ay;
        logic signed [RAW_W-1:0]  az;
        logic [2:0]               neg;
        logic [2:0][MAG_W-1:0]    mag;
        logic [TIME_W-1:0]        dt;
    } imu_item_t;

    typedef struct packed {
        logic [DIV_W-1:0] divisor;
        logic [WGT_W-1:0] weight;
    } imu_cfg_t;

    // atan(2^-i) in Q16 degrees
    function automatic logic [21:0] atan_q16(input logic [4:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117305;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111)
            r = v[31:0];
        else if (v[35])
            r = 32'sh8000_0000;
        else
            r = 32'sh7FFF_FFFF;
        return r;
    endfunction

endpackage

FILE: rtl/imuctf_front.sv
// ----------------------------------------------------------------------------
// imuctf_front
// Accepts samples, holds configuration and timestamp, computes elapsed time
// and bias-corrected gyro magnitudes, and pushes work items to the queue.
// ----------------------------------------------------------------------------
module imuctf_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [imuctf_pkg::IN_W-1:0]            s_tdata,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [imuctf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [imuctf_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                   q_full,
    output logic                                   q_push,
    output imuctf_pkg::imu_item_t                  q_item,
    output imuctf_pkg::imu_cfg_t                   cfg
);

    logic signed [imuctf_pkg::BIAS_W-1:0] bias_reg [3];
    logic [imuctf_pkg::SENS_W-1:0]        sens_reg;
    logic [imuctf_pkg::WGT_W-1:0]         weight_reg;
    logic [imuctf_pkg::TIME_W-1:0]        prev_time_reg;
    logic [imuctf_pkg::SENS_W-1:0]        sens_eff;
    logic [imuctf_pkg::TIME_W-1:0]        now;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign q_push    = s_tvalid && !q_full;
    assign now       = s_tdata[127:96];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg[0]   <= '0;
            bias_reg[1]   <= '0;
            bias_reg[2]   <= '0;
            sens_reg      <= imuctf_pkg::SENS_RESET;
            weight_reg    <= imuctf_pkg::WEIGHT_RESET;
            prev_time_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    imuctf_pkg::REG_BIAS_X: bias_reg[0] <= cfg_data;
                    imuctf_pkg::REG_BIAS_Y: bias_reg[1] <= cfg_data;
                    imuctf_pkg::REG_BIAS_Z: bias_reg[2] <= cfg_data;
                    imuctf_pkg::REG_SENS:   sens_reg    <= cfg_data[imuctf_pkg::SENS_W-1:0];
                    imuctf_pkg::REG_WEIGHT: weight_reg  <= cfg_data[imuctf_pkg::WGT_W-1:0];
                    default: ;
                endcase
            end
            if (q_push)
                prev_time_reg <= now;
        end
    end

    always_comb
    begin
        logic signed [20:0] d;
        logic [20:0]        m;
        q_item.ax  = s_tdata[15:0];
        q_item.ay  = s_tdata[31:16];
        q_item.az  = s_tdata[47:32];
        q_item.dt  = now - prev_time_reg;
        for (int k = 0; k < 3; k++)
        begin
            // d = 16*raw - bias, Q4 raw units
            d = {s_tdata[48+16*k+15], s_tdata[48+16*k +: 16], 4'b0000}
              - {bias_reg[k][imuctf_pkg::BIAS_W-1], bias_reg[k]};
            m = d[20] ? (21'd0 - d) : d;
            q_item.neg[k] = d[20];
            q_item.mag[k] = m[imuctf_pkg::MAG_W-1:0];
        end
    end

    assign sens_eff    = (sens_reg == '0) ? 8'd1 : sens_reg;
    assign cfg.divisor = imuctf_pkg::DIV_W'(sens_eff * imuctf_pkg::SENS_SCALE);
    assign cfg.weight  = (weight_reg > imuctf_pkg::WEIGHT_ONE) ? imuctf_pkg::WEIGHT_ONE
                                                               : weight_reg;

endmodule

FILE: rtl/imuctf_queue.sv
// ----------------------------------------------------------------------------
// imuctf_queue
// Two-entry queue of work items between front and back.
// ----------------------------------------------------------------------------
module imuctf_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  imuctf_pkg::imu_item_t  item_in,
    output logic                   full,
    input  logic                   pop,
    output logic                   valid,
    output imuctf_pkg::imu_item_t  item_out
);

    imuctf_pkg::imu_item_t mem_reg [2];
    logic                  wr_ptr_reg;
    logic                  rd_ptr_reg;
    logic [1:0]            count_reg;

    assign full     = (count_reg == 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign item_out = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= item_in;
    end

endmodule

FILE: rtl/imuctf_back.sv
// ----------------------------------------------------------------------------
// imuctf_back
// Sequencer: gyro integration through a radix-16 divider, accelerometer tilt
// through a bit-serial square root and CORDIC vectoring, then the blend.
// ----------------------------------------------------------------------------
module imuctf_back #(
    parameter int CORDIC_STEPS = imuctf_pkg::CORDIC_STEPS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  imuctf_pkg::imu_item_t        q_item,
    output logic                         q_pop,
    input  imuctf_pkg::imu_cfg_t         cfg,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [imuctf_pkg::OUT_W-1:0] m_tdata
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL_LO, ST_MUL_HI, ST_DIV, ST_INTEG, ST_SQ_A, ST_SQ_B,
        ST_SQRT, ST_CINIT, ST_CORDIC, ST_BL_A, ST_BL_B, ST_BL_C, ST_DONE
    } state_t;

    localparam logic [4:0] DIV_LAST  = 5'd15;
    localparam logic [4:0] SQRT_LAST = 5'd23;
    localparam logic [4:0] CORD_LAST = 5'(CORDIC_STEPS - 1);

    state_t                   state_reg;
    logic [1:0]               axis_reg;
    logic                     tsel_reg;
    logic [4:0]               cnt_reg;
    logic                     out_valid_reg;
    logic signed [31:0]       fa_reg [3];
    logic signed [31:0]       go_reg [3];

    imuctf_pkg::imu_item_t    item_reg;
    logic [35:0]              prod_reg;
    logic [63:0]              dq_reg;
    logic [17:0]              rem_reg;
    logic signed [31:0]       ga_reg [3];
    logic signed [31:0]       acc_reg [2];
    logic signed [31:0]       fb_reg [2];
    logic [30:0]              sqa_reg;
    logic [47:0]              sv_reg;
    logic [25:0]              srem_reg;
    logic [23:0]              root_reg;
    logic signed [27:0]       cx_reg;
    logic signed [27:0]       cy_reg;
    logic signed [31:0]       cz_reg;
    logic signed [49:0]       pa_reg;
    logic signed [49:0]       pb_reg;
    logic [imuctf_pkg::OUT_W-1:0] out_data_reg;

    // ---- datapath steps
    logic [17:0]              div_rem_next;
    logic [63:0]              div_dq_next;
    logic [25:0]              sq_rem_next;
    logic [23:0]              sq_root_next;
    logic signed [27:0]       cx_next;
    logic signed [27:0]       cy_next;
    logic signed [31:0]       cz_next;
    logic signed [35:0]       inc;
    logic signed [31:0]       ga_new;
    logic signed [31:0]       go_new;
    logic signed [15:0]       tilt_a;
    logic signed [16:0]       tilt_num;
    logic signed [31:0]       blend_out;
    logic                     out_free;

    always_comb
    begin
        logic [17:0] r;
        logic [63:0] d;
        logic [18:0] t;
        r = rem_reg;
        d = dq_reg;
        for (int j = 0; j < 4; j++)
        begin
            t = {r, d[63]};
            d = {d[62:0], 1'b0};
            if (t >= {1'b0, cfg.divisor})
            begin
                t    = t - {1'b0, cfg.divisor};
                d[0] = 1'b1;
            end
            r = t[17:0];
        end
        div_rem_next = r;
        div_dq_next  = d;
    end

    always_comb
    begin
        logic [27:0] r2;
        logic [27:0] trial;
        r2    = {srem_reg, sv_reg[47:46]};
        trial = {2'b00, root_reg, 2'b01};
        if (r2 >= trial)
        begin
            sq_rem_next  = 26'(r2 - trial);
            sq_root_next = {root_reg[22:0], 1'b1};
        end
        else
        begin
            sq_rem_next  = r2[25:0];
            sq_root_next = {root_reg[22:0], 1'b0};
        end
    end

    always_comb
    begin
        logic signed [27:0] xs;
        logic signed [27:0] ys;
        logic signed [31:0] at;
        xs = cx_reg >>> cnt_reg;
        ys = cy_reg >>> cnt_reg;
        at = $signed({10'd0, imuctf_pkg::atan_q16(cnt_reg)});
        cx_next = cx_reg;
        cy_next = cy_reg;
        cz_next = cz_reg;
        if (cy_reg > 0)
        begin
            cx_next = cx_reg + ys;
            cy_next = cy_reg - xs;
            cz_next = cz_reg + at;
        end
        else if (cy_reg < 0)
        begin
            cx_next = cx_reg - ys;
            cy_next = cy_reg + xs;
            cz_next = cz_reg - at;
        end
    end

    // increments of 2^34 and up clamp to 2^33, which still saturates any 32-bit angle
    always_comb
    begin
        logic [35:0] m;
        m   = (dq_reg[63:34] != '0) ? 36'h2_0000_0000 : {2'b00, dq_reg[33:0]};
        inc = item_reg.neg[axis_reg] ? $signed(36'd0 - m) : $signed(m);
        ga_new = imuctf_pkg::sat32(36'(fa_reg[axis_reg]) + inc);
        go_new = imuctf_pkg::sat32(36'(go_reg[axis_reg]) + inc);
    end

    assign tilt_a   = tsel_reg ? item_reg.ay : item_reg.ax;
    assign tilt_num = tsel_reg ? (17'sd0 - 17'(item_reg.ax)) : 17'(item_reg.ay);

    always_comb
    begin
        logic signed [51:0] s;
        s = 52'(pa_reg) + 52'(pb_reg) + 52'sd32768;
        blend_out = imuctf_pkg::sat32(s[51:16]);
    end

    assign out_free = !out_valid_reg || m_tready;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ---- control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= 2'd0;
            tsel_reg      <= 1'b0;
            cnt_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                fa_reg[k] <= '0;
                go_reg[k] <= '0;
            end
        end
        else
        begin
            // in ST_DONE the valid flag is handled by the state arm
            if ((state_reg != ST_DONE) && out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    axis_reg <= 2'd0;
                    if (q_valid)
                        state_reg <= ST_MUL_LO;
                end
                ST_MUL_LO: state_reg <= ST_MUL_HI;
                ST_MUL_HI:
                begin
                    cnt_reg   <= 5'd0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == DIV_LAST)
                        state_reg <= ST_INTEG;
                end
                ST_INTEG:
                begin
                    go_reg[axis_reg] <= go_new;
                    if (axis_reg == 2'd2)
                    begin
                        tsel_reg  <= 1'b0;
                        state_reg <= ST_SQ_A;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= ST_MUL_LO;
                    end
                end
                ST_SQ_A: state_reg <= ST_SQ_B;
                ST_SQ_B:
                begin
                    cnt_reg   <= 5'd0;
                    state_reg <= ST_SQRT;
                end
                ST_SQRT:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == SQRT_LAST)
                        state_reg <= ST_CINIT;
                end
                ST_CINIT:
                begin
                    cnt_reg <= 5'd0;
                    if (root_reg != '0)
                        state_reg <= ST_CORDIC;
                    else if (tsel_reg)
                    begin
                        tsel_reg  <= 1'b0;
                        state_reg <= ST_BL_A;
                    end
                    else
                    begin
                        tsel_reg  <= 1'b1;
                        state_reg <= ST_SQ_A;
                    end
                end
                ST_CORDIC:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == CORD_LAST)
                    begin
                        tsel_reg  <= !tsel_reg;
                        state_reg <= tsel_reg ? ST_BL_A : ST_SQ_A;
                    end
                end
                ST_BL_A: state_reg <= ST_BL_B;
                ST_BL_B: state_reg <= ST_BL_C;
                ST_BL_C:
                begin
                    tsel_reg  <= !tsel_reg;
                    state_reg <= tsel_reg ? ST_DONE : ST_BL_A;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        fa_reg[0]     <= fb_reg[0];
                        fa_reg[1]     <= fb_reg[1];
                        fa_reg[2]     <= ga_reg[2];
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // ---- datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (q_valid)
                    item_reg <= q_item;
            ST_MUL_LO:
                prod_reg <= item_reg.mag[axis_reg] * item_reg.dt[15:0];
            ST_MUL_HI:
            begin
                // numerator scaled by 4096 for the Q16 result with ms units
                dq_reg  <= {52'(prod_reg)
                            + {36'(item_reg.mag[axis_reg]) * 36'(item_reg.dt[31:16]),
                               16'd0},
                            12'd0};
                rem_reg <= '0;
            end
            ST_DIV:
            begin
                dq_reg  <= div_dq_next;
                rem_reg <= div_rem_next;
            end
            ST_INTEG:
                ga_reg[axis_reg] <= ga_new;
            ST_SQ_A:
                sqa_reg <= 31'(tilt_a * tilt_a);
            ST_SQ_B:
            begin
                sv_reg   <= {32'(sqa_reg) + 32'(item_reg.az * item_reg.az), 16'd0};
                srem_reg <= '0;
                root_reg <= '0;
            end
            ST_SQRT:
            begin
                sv_reg   <= {sv_reg[45:0], 2'b00};
                srem_reg <= sq_rem_next;
                root_reg <= sq_root_next;
            end
            ST_CINIT:
            begin
                cx_reg <= $signed({4'd0, root_reg});
                cy_reg <= 28'($signed({tilt_num, 8'd0}));
                cz_reg <= '0;
                // vertical case: no horizontal component
                if (tilt_num > 0)
                    acc_reg[tsel_reg] <= imuctf_pkg::DEG90_Q16;
                else if (tilt_num < 0)
                    acc_reg[tsel_reg] <= -imuctf_pkg::DEG90_Q16;
                else
                    acc_reg[tsel_reg] <= '0;
            end
            ST_CORDIC:
            begin
                cx_reg <= cx_next;
                cy_reg <= cy_next;
                cz_reg <= cz_next;
                if (cnt_reg == CORD_LAST)
                    acc_reg[tsel_reg] <= cz_next;
            end
            ST_BL_A:
                pa_reg <= $signed({1'b0, cfg.weight}) * ga_reg[tsel_reg];
            ST_BL_B:
                pb_reg <= $signed({1'b0, imuctf_pkg::WEIGHT_ONE - cfg.weight})
                          * acc_reg[tsel_reg];
            ST_BL_C:
                fb_reg[tsel_reg] <= blend_out;
            ST_DONE:
                if (out_free)
                    out_data_reg <= {go_reg[2], go_reg[1], go_reg[0],
                                     ga_reg[2], fb_reg[1], fb_reg[0]};
            default: ;
        endcase
    end

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == ST_IDLE) && q_valid)
        else $error("queue popped outside idle");

    a_cordic_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CORDIC) |-> (cnt_reg <= CORD_LAST))
        else $error("cordic step count overrun");

    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) && (cnt_reg == DIV_LAST) |=> (state_reg == ST_INTEG))
        else $error("divider did not finish");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) && out_valid_reg && !m_tready |=> (state_reg == ST_DONE))
        else $error("result overwrote a pending transfer");

endmodule

FILE: rtl/imu_complementary_tilt_filter.sv
// ----------------------------------------------------------------------------
// imu_complementary_tilt_filter
// Complementary filter: gyro-integrated angles blended with accelerometer
// tilt, plus gyro-only integrated angles.
//
//  channel   dir  handshake              payload
//  s_*       in   s_tvalid / s_tready    s_tdata  128b sample
//  m_*       out  m_tvalid / m_tready    m_tdata  192b angles
//  cfg_*     in   cfg_valid / cfg_ready  cfg_index 3b, cfg_data 20b
//
// The shared sequencer takes the sample, then runs per gyro axis the low and
// high multiply, a 4-bit-per-cycle divider and the integrate step; per tilt
// angle the squares, a one-bit square root, the CORDIC init and the CORDIC
// loop; then the blend, and a last state to hand off the result. A zero
// denominator skips its CORDIC loop.
// Reset clears angles, timestamp and registers to their defaults.
// A two-entry queue takes samples while the back end works; the output
// register holds a result under m_tready low while the next sample proceeds.
// ----------------------------------------------------------------------------
module imu_complementary_tilt_filter #(
    parameter int CORDIC_STEPS = imuctf_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // accel_raw_x, accel_raw_y, accel_raw_z, gyro_raw_x, gyro_raw_y,
    // gyro_raw_z, sample_time_ms
    input  logic [imuctf_pkg::IN_W-1:0]          s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // fused_angle_x, fused_angle_y, fused_angle_z, gyro_only_angle_x,
    // gyro_only_angle_y, gyro_only_angle_z
    output logic [imuctf_pkg::OUT_W-1:0]         m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [imuctf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [imuctf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    imuctf_pkg::imu_item_t push_item;
    imuctf_pkg::imu_item_t pop_item;
    imuctf_pkg::imu_cfg_t  cfg;
    logic                  q_full;
    logic                  q_push;
    logic                  q_valid;
    logic                  q_pop;

    imuctf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item),
        .cfg       (cfg)
    );

    imuctf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .item_in  (push_item),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .item_out (pop_item)
    );

    imuctf_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (pop_item),
        .q_pop    (q_pop),
        .cfg      (cfg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
